// ----- design/tak_pkg.sv -----
`timescale 1ns / 1ps
package tak_pkg;

    // CORDIC rotation count; the angle table has 24 entries
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    // register indexes of the configuration port
    localparam logic [2:0] REG_GYRO_BIAS     = 3'd0;
    localparam logic [2:0] REG_GYRO_SCALE    = 3'd1;
    localparam logic [2:0] REG_TIME_STEP     = 3'd2;
    localparam logic [2:0] REG_PROCESS_NOISE = 3'd3;
    localparam logic [2:0] REG_MEASURE_NOISE = 3'd4;

    // reset values
    localparam logic [23:0] RST_GYRO_SCALE    = 24'd146801;
    localparam logic [23:0] RST_TIME_STEP     = 24'd335544;
    localparam logic [23:0] RST_PROCESS_NOISE = 24'd167772;
    localparam logic [23:0] RST_MEASURE_NOISE = 24'd655360;
    localparam logic signed [31:0] DEG90_Q16  = 32'sd5898240;
    localparam logic signed [31:0] ONE_Q28    = 32'sd268435456;

    // atan(2^-i) in degrees, Q16.16
    function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // clamp a wide value to signed 32 bit
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (&v[67:31] || ~|v[67:31]) begin
            r = v[31:0];
        end else if (v[67]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // clamp to signed 25 bit
    function automatic logic signed [24:0] sat25(input logic signed [31:0] v);
        logic signed [24:0] r;
        if (&v[31:24] || ~|v[31:24]) begin
            r = v[24:0];
        end else if (v[31]) begin
            r = 25'sh100_0000;
        end else begin
            r = 25'sh0FF_FFFF;
        end
        return r;
    endfunction

endpackage

// ----- design/tak_ifs.sv -----
`timescale 1ns / 1ps

interface tak_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gyro_rate_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    modport source (output valid, gyro_rate_raw, accel_y_raw, accel_z_raw, input ready);
    modport sink   (input valid, gyro_rate_raw, accel_y_raw, accel_z_raw, output ready);
endinterface

interface tak_out_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] fused_angle;
    modport source (output valid, fused_angle, input ready);
    modport sink   (input valid, fused_angle, output ready);
endinterface

interface tak_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/tilt_angle_kalman_fusion.sv -----
`timescale 1ns / 1ps
// Tilt angle fusion: each input beat (gyro X rate, accel Y and Z) yields one output beat
// with the Kalman-filtered angle in degrees, Q16.16, saturated to 25 bits. One item is
// processed at a time and the input is not ready meanwhile. An accepted item runs through
// the CORDIC steps, the first seven of 13 products on the single shared 34x34 multiplier,
// two bit-serial gain divisions of 60 quotient bits each, the other six products and the
// output register load; only then can the next item be taken. An all-zero accelerometer
// sample skips the CORDIC, and a non-positive gain denominator skips both divisions. A
// finished result waits in the output register while the next item is taken; if it is
// still waiting when the next item finishes, the block holds until it is taken.
// Configuration writes are taken only while the block is idle.
module tilt_angle_kalman_fusion
    import tak_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    tak_in_if.sink   i_in,
    tak_out_if.source o_out,
    tak_cfg_if.sink  i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_MUL, S_WB, S_DIVI, S_DIV, S_DIVE, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_RATE, OP_DT2, OP_APR, OP_T1, OP_T2, OP_T3, OP_T4,
        OP_KA, OP_KB, OP_P00, OP_P01, OP_P10, OP_P11
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic [5:0] r_cnt;
    logic       r_dsel;

    // configuration
    logic signed [23:0] r_gb;
    logic [23:0] r_gs, r_dt, r_qn, r_mn;

    // filter state
    logic signed [31:0] r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;

    // per-item working registers
    logic signed [15:0] r_gx;
    logic signed [34:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic signed [31:0] r_rate, r_apr, r_innov, r_p0, r_p1, r_p2, r_p3, r_k1, r_k2;
    logic [23:0]        r_dt2;
    logic signed [39:0] r_acc;
    logic signed [67:0] r_prod;
    logic [36:0]        r_den;
    logic [36:0]        r_rem;
    logic [59:0]        r_dnum;
    logic               r_dneg;

    // output register
    logic               r_oval;
    logic signed [24:0] r_ofa;

    assign i_in.ready        = (r_state == S_IDLE) && i_rst_n;
    assign i_cfg.ready       = (r_state == S_IDLE) && i_rst_n;
    assign o_out.valid       = r_oval;
    assign o_out.fused_angle = r_ofa;

    // accept: quadrant pre-rotation of (x, y) = (-az, ay) scaled by 2^16
    logic signed [34:0] ix, iy;
    logic               izero;
    always_comb begin
        ix    = -($signed({{19{i_in.accel_z_raw[15]}}, i_in.accel_z_raw}) <<< 16);
        iy    = $signed({{19{i_in.accel_y_raw[15]}}, i_in.accel_y_raw}) <<< 16;
        izero = (i_in.accel_y_raw == 16'sd0) && (i_in.accel_z_raw == 16'sd0);
    end

    // CORDIC step
    logic signed [34:0] cdx, cdy;
    logic signed [31:0] cat;
    always_comb begin
        cdx = r_cy >>> r_cnt;
        cdy = r_cx >>> r_cnt;
        cat = atan_deg(r_cnt[4:0]);
    end

    // shared multiplier operands
    logic signed [33:0] ma, mb;
    logic signed [33:0] dt34, dt2_34;
    always_comb begin
        dt34   = $signed({10'd0, r_dt});
        dt2_34 = $signed({10'd0, r_dt2});
        case (r_op)
            OP_RATE: begin
                ma = $signed({{10{r_gx[15]}}, r_gx, 8'd0}) - $signed({{10{r_gb[23]}}, r_gb});
                mb = $signed({10'd0, r_gs});
            end
            OP_DT2:  begin ma = dt34; mb = dt34; end
            OP_APR:  begin
                ma = $signed({{2{r_rate[31]}}, r_rate}) - $signed({{2{r_bias[31]}}, r_bias});
                mb = dt34;
            end
            OP_T1:   begin ma = 34'(r_p10); mb = dt34; end
            OP_T2:   begin ma = 34'(r_p01); mb = dt34; end
            OP_T3:   begin ma = 34'(r_p11); mb = dt2_34; end
            OP_T4:   begin ma = 34'(r_p11); mb = dt34; end
            OP_KA:   begin ma = 34'(r_k1); mb = 34'(r_innov); end
            OP_KB:   begin ma = 34'(r_k2); mb = 34'(r_innov); end
            OP_P00:  begin ma = 34'(r_k1); mb = 34'(r_p0); end
            OP_P01:  begin ma = 34'(r_k1); mb = 34'(r_p1); end
            OP_P10:  begin ma = 34'(r_k2); mb = 34'(r_p0); end
            OP_P11:  begin ma = 34'(r_k2); mb = 34'(r_p1); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // write-back: scale product, add to or subtract from a base, clamp
    logic signed [67:0] sh, base, res, qn68, wb_p2, wb_p3;
    logic               wsub;
    always_comb begin
        qn68 = $signed({40'd0, r_qn, 4'd0});
        case (r_op)
            OP_RATE: sh = r_prod >>> 16;
            OP_KA, OP_KB, OP_P00, OP_P01, OP_P10, OP_P11: sh = r_prod >>> 28;
            default: sh = r_prod >>> 24;
        endcase
        wsub = 1'b0;
        case (r_op)
            OP_APR:  base = 68'(r_angle);
            OP_T1:   begin base = 68'(r_p00) + qn68; wsub = 1'b1; end
            OP_T2:   begin base = 68'(r_acc); wsub = 1'b1; end
            OP_T3:   base = 68'(r_acc);
            OP_T4:   begin base = 68'(r_p01); wsub = 1'b1; end
            OP_KA:   base = 68'(r_apr);
            OP_KB:   base = 68'(r_bias);
            OP_P00:  begin base = 68'(r_p0); wsub = 1'b1; end
            OP_P01:  begin base = 68'(r_p1); wsub = 1'b1; end
            OP_P10:  begin base = 68'(r_p2); wsub = 1'b1; end
            OP_P11:  begin base = 68'(r_p3); wsub = 1'b1; end
            default: base = '0;
        endcase
        res   = wsub ? (base - sh) : (base + sh);
        wb_p2 = 68'(r_p10) - sh;
        wb_p3 = 68'(r_p11) + qn68;
    end

    // accelerometer angle minus prediction
    logic signed [67:0] innov68;
    always_comb begin
        innov68 = 68'(r_cz + DEG90_Q16) - 68'(r_apr);
    end

    // divider: shared denominator P00' + R, one quotient bit per cycle
    logic signed [37:0] den38;
    logic signed [31:0] dnum_sel;
    logic [31:0]        dmag;
    logic [37:0]        rem_sh, rem_dif;
    logic               rem_ge;
    logic signed [31:0] kval;
    always_comb begin
        den38    = $signed({{6{r_p0[31]}}, r_p0}) + $signed({2'd0, r_mn, 12'd0});
        dnum_sel = r_dsel ? r_p2 : r_p0;
        dmag     = dnum_sel[31] ? 32'(-dnum_sel) : 32'(dnum_sel);
        rem_sh   = {r_rem, r_dnum[59]};
        rem_dif  = rem_sh - {1'b0, r_den};
        rem_ge   = (rem_sh >= {1'b0, r_den});
        if (!r_dneg) begin
            kval = (|r_dnum[59:31]) ? 32'sh7FFF_FFFF : $signed(r_dnum[31:0]);
        end else begin
            kval = (r_dnum > 60'h0_0000_8000_0000) ? 32'sh8000_0000
                                                    : $signed(32'(-r_dnum[31:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_RATE;
            r_cnt   <= '0;
            r_dsel  <= 1'b0;
            r_oval  <= 1'b0;
            r_gb    <= '0;
            r_gs    <= RST_GYRO_SCALE;
            r_dt    <= RST_TIME_STEP;
            r_qn    <= RST_PROCESS_NOISE;
            r_mn    <= RST_MEASURE_NOISE;
            r_angle <= DEG90_Q16;
            r_bias  <= '0;
            r_p00   <= ONE_Q28;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= ONE_Q28;
        end else begin
            // configuration writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_GYRO_BIAS:     r_gb <= $signed(i_cfg.data);
                    REG_GYRO_SCALE:    r_gs <= i_cfg.data;
                    REG_TIME_STEP:     r_dt <= i_cfg.data;
                    REG_PROCESS_NOISE: r_qn <= i_cfg.data;
                    REG_MEASURE_NOISE: r_mn <= i_cfg.data;
                    default: ;
                endcase
            end

            // drop the result once taken; S_OUT reloads it itself
            if (o_out.ready && r_state != S_OUT) begin
                r_oval <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_gx  <= i_in.gyro_rate_raw;
                        r_cnt <= '0;
                        r_op  <= OP_RATE;
                        if (izero) begin
                            r_cz    <= '0;
                            r_state <= S_MUL;
                        end else begin
                            if (ix < 0) begin
                                if (iy >= 0) begin
                                    r_cx <= iy; r_cy <= -ix; r_cz <= DEG90_Q16;
                                end else begin
                                    r_cx <= -iy; r_cy <= ix; r_cz <= -DEG90_Q16;
                                end
                            end else begin
                                r_cx <= ix; r_cy <= iy; r_cz <= '0;
                            end
                            r_state <= S_CORDIC;
                        end
                    end
                end
                S_CORDIC: begin
                    // rotate toward the x axis
                    if (r_cy > 0) begin
                        r_cx <= r_cx + cdx; r_cy <= r_cy - cdy; r_cz <= r_cz + cat;
                    end else begin
                        r_cx <= r_cx - cdx; r_cy <= r_cy + cdy; r_cz <= r_cz - cat;
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(CORDIC_ITERS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= ma * mb;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_state <= S_MUL;
                    case (r_op)
                        OP_RATE: begin r_rate <= sat32(res); r_op <= OP_DT2; end
                        OP_DT2:  begin r_dt2 <= sh[23:0]; r_op <= OP_APR; end
                        OP_APR:  begin r_apr <= sat32(res); r_op <= OP_T1; end
                        OP_T1: begin
                            r_acc   <= res[39:0];
                            r_innov <= sat32(innov68);
                            r_op    <= OP_T2;
                        end
                        OP_T2:   begin r_acc <= res[39:0]; r_op <= OP_T3; end
                        OP_T3:   begin r_p0 <= sat32(res); r_op <= OP_T4; end
                        OP_T4: begin
                            r_p1    <= sat32(res);
                            r_p2    <= sat32(wb_p2);
                            r_p3    <= sat32(wb_p3);
                            r_dsel  <= 1'b0;
                            r_op    <= OP_KA;
                            r_state <= S_DIVI;
                        end
                        OP_KA:   begin r_angle <= sat32(res); r_op <= OP_KB; end
                        OP_KB:   begin r_bias <= sat32(res); r_op <= OP_P00; end
                        OP_P00:  begin r_p00 <= sat32(res); r_op <= OP_P01; end
                        OP_P01:  begin r_p01 <= sat32(res); r_op <= OP_P10; end
                        OP_P10:  begin r_p10 <= sat32(res); r_op <= OP_P11; end
                        OP_P11: begin
                            r_p11   <= sat32(res);
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_DIVI: begin
                    // non-positive denominator: zero both gains and skip the divisions
                    if (den38[37] || den38 == '0) begin
                        r_k1    <= '0;
                        r_k2    <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_den   <= den38[36:0];
                        r_rem   <= '0;
                        r_dnum  <= {dmag, 28'd0};
                        r_dneg  <= dnum_sel[31];
                        r_cnt   <= 6'd60;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? rem_dif[36:0] : rem_sh[36:0];
                    r_dnum <= {r_dnum[58:0], rem_ge};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= S_DIVE;
                    end
                end
                S_DIVE: begin
                    if (!r_dsel) begin
                        r_k1    <= kval;
                        r_dsel  <= 1'b1;
                        r_state <= S_DIVI;
                    end else begin
                        r_k2    <= kval;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_oval || o_out.ready) begin
                        r_ofa   <= sat25(r_angle);
                        r_oval  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
